[rtl/core/sact_pkg.sv]
package sact_pkg;

  localparam int DEF_MAX_SETS     = 256;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDRESS_BITS = 48;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_POLICY = 2'd2;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // settings snapshot that travels with each transaction
  typedef struct packed {
    logic [3:0] idx_bits;
    logic [4:0] ways;
    logic       lru;
  } sact_ctl_t;

endpackage

[rtl/core/set_assoc_cache_tag_store.sv]
// set-associative tag store, lru or fifo replacement
// a transaction taken from the queue has its row read, then updated and written back
// while its result is registered; the next is taken only once that is done and the
// result register is free or being popped
// reset: synchronous active low; a clearing pass over all MAX_SETS rows follows, during
// which up to two transactions wait in the queue and none completes (config writes taken)
module set_assoc_cache_tag_store
  import sact_pkg::*;
#(
  parameter int MAX_SETS     = DEF_MAX_SETS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [ADDRESS_BITS-1:0] in_block_address,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic                    out_hit,
  output logic                    out_replaced,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int SET_W = $clog2(MAX_SETS+1);

  logic                    q_valid, q_pop;
  logic [ADDRESS_BITS-1:0] q_addr;
  logic [SET_W-1:0]        q_set;
  sact_ctl_t               q_ctl;

  // front: config registers, set decode, small queue
  sact_front #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS),
               .ADDRESS_BITS(ADDRESS_BITS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_block_address,
    .cfg_we, .cfg_index, .cfg_data,
    .q_valid, .q_pop, .q_addr, .q_set, .q_ctl
  );

  // back: row read, hit/victim logic, write-back, result register
  sact_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS),
              .ADDRESS_BITS(ADDRESS_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_addr, .q_set, .q_ctl,
    .out_empty, .out_pop, .out_hit, .out_replaced
  );

endmodule

[rtl/core/sact_front.sv]
module sact_front
  import sact_pkg::*;
#(
  parameter int MAX_SETS     = DEF_MAX_SETS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [ADDRESS_BITS-1:0] in_block_address,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // queue toward the back part
  output logic                    q_valid,
  input  logic                    q_pop,
  output logic [ADDRESS_BITS-1:0] q_addr,
  output logic [$clog2(MAX_SETS+1)-1:0] q_set,
  output sact_ctl_t               q_ctl
);

  localparam int SET_W   = $clog2(MAX_SETS+1);
  localparam int MAXBITS = $clog2(MAX_SETS+1) - 1;
  localparam int QD      = 2;

  logic [3:0] sib_r;
  logic [3:0] wiu_r;
  logic       pol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sib_r <= 4'd0;
      wiu_r <= 4'd1;
      pol_r <= POLICY_LRU;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_INDEX_BITS: sib_r <= cfg_data;
        REG_WAYS_IN_USE:    wiu_r <= cfg_data;
        REG_REPLACE_POLICY: pol_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // classify: clamp settings and compute set number
  logic [3:0]       bits_c;
  logic [4:0]       ways_c;
  logic [SET_W-1:0] set_c;
  logic [SET_W-1:0] mask_c;

  always_comb begin
    bits_c = (32'(sib_r) > MAXBITS) ? 4'(MAXBITS) : sib_r;
    if (wiu_r == 4'd0)                 ways_c = 5'd1;
    else if (32'(wiu_r) > MAX_WAYS)    ways_c = 5'(MAX_WAYS);
    else                               ways_c = {1'b0, wiu_r};
    mask_c = SET_W'((33'd1 << bits_c) - 33'd1);
    set_c  = SET_W'(in_block_address) & mask_c;
  end

  // two entry queue
  logic [ADDRESS_BITS-1:0] qa_r [QD];
  logic [SET_W-1:0]        qs_r [QD];
  sact_ctl_t               qc_r [QD];
  logic                    wp_r, rp_r;
  logic [1:0]              cnt_r;
  logic                    push_ok;

  assign in_full = (cnt_r == 2'(QD));
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_addr  = qa_r[rp_r];
  assign q_set   = qs_r[rp_r];
  assign q_ctl   = qc_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      qa_r[wp_r] <= in_block_address;
      qs_r[wp_r] <= set_c;
      qc_r[wp_r] <= '{idx_bits: bits_c, ways: ways_c, lru: pol_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok)           wp_r <= ~wp_r;
      if (q_pop && q_valid)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(q_pop && q_valid);
    end
  end

endmodule

[rtl/core/sact_back.sv]
module sact_back
  import sact_pkg::*;
#(
  parameter int MAX_SETS     = DEF_MAX_SETS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [ADDRESS_BITS-1:0] q_addr,
  input  logic [$clog2(MAX_SETS+1)-1:0] q_set,
  input  sact_ctl_t               q_ctl,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic                    out_hit,
  output logic                    out_replaced
);

  localparam int SET_W = $clog2(MAX_SETS+1);
  localparam int SA_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int RK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int FL_W  = $clog2(MAX_WAYS+1);
  localparam int ROW_W = MAX_WAYS * (ADDRESS_BITS + RK_W + 1) + FL_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] tag;
    logic [MAX_WAYS-1:0][RK_W-1:0]         rank;
    logic [MAX_WAYS-1:0]                   valid;
    logic [FL_W-1:0]                       fill;
  } row_t;

  // one row per set; cleared by a sweep after reset
  row_t            mem [MAX_SETS];
  row_t            rd_r;
  logic [1:0]      st_r;
  logic [SA_W-1:0] clr_r;
  logic [SA_W-1:0] sa_r;
  logic [ADDRESS_BITS-1:0] a_r;
  logic            lru_r;
  logic [4:0]      ways_r;
  logic            ov_r, oh_r, orp_r;

  logic            we;
  logic [SA_W-1:0] wa;
  row_t            wd, nr;
  logic            hit_c, rep_c;

  // a result leaving in the same cycle frees the result register
  assign q_pop        = (st_r == ST_IDLE) && q_valid && (!ov_r || out_pop);
  assign out_empty    = !ov_r;
  assign out_hit      = oh_r;
  assign out_replaced = orp_r;

  always_comb begin
    logic [RK_W-1:0] hr, pr;
    logic            found, pf;
    logic [RK_W-1:0] hw, pw, fw;
    logic            ff;
    nr    = rd_r;
    hit_c = 1'b0;
    rep_c = 1'b0;
    found = 1'b0; hw = '0; hr = '0;
    for (int w = 0; w < MAX_WAYS; w++)
      if (!found && rd_r.valid[w] && rd_r.tag[w] == a_r) begin
        found = 1'b1; hw = RK_W'(w); hr = rd_r.rank[w];
      end
    ff = 1'b0; fw = '0;
    for (int w = 0; w < MAX_WAYS; w++)
      if (!ff && !rd_r.valid[w]) begin ff = 1'b1; fw = RK_W'(w); end
    pf = 1'b0; pw = '0; pr = '0;
    for (int w = 0; w < MAX_WAYS; w++)
      if (rd_r.valid[w] && (!pf || rd_r.rank[w] > pr)) begin
        pf = 1'b1; pw = RK_W'(w); pr = rd_r.rank[w];
      end
    if (found) begin
      hit_c = 1'b1;
      if (lru_r) begin
        for (int w = 0; w < MAX_WAYS; w++)
          if (rd_r.valid[w] && rd_r.rank[w] < hr) nr.rank[w] = rd_r.rank[w] + 1'b1;
        nr.rank[hw] = '0;
      end
    end else if (32'(rd_r.fill) < 32'(ways_r)) begin
      if (ff) begin
        for (int w = 0; w < MAX_WAYS; w++)
          if (rd_r.valid[w]) nr.rank[w] = rd_r.rank[w] + 1'b1;
        nr.valid[fw] = 1'b1;
        nr.tag[fw]   = a_r;
        nr.rank[fw]  = '0;
        nr.fill      = rd_r.fill + 1'b1;
      end
    end else if (pf) begin
      for (int w = 0; w < MAX_WAYS; w++)
        if (rd_r.valid[w] && rd_r.rank[w] < pr) nr.rank[w] = rd_r.rank[w] + 1'b1;
      nr.tag[pw]  = a_r;
      nr.rank[pw] = '0;
      rep_c = 1'b1;
    end
  end

  always_comb begin
    we = 1'b0; wa = sa_r; wd = nr;
    if (st_r == ST_CLEAR) begin
      we = 1'b1; wa = clr_r; wd = '0;
    end else if (st_r == ST_LOOK) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[SA_W'(q_set)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (out_pop && ov_r) ov_r <= 1'b0;
      unique case (st_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == MAX_SETS - 1) st_r <= ST_IDLE;
        end
        ST_IDLE: if (q_pop) st_r <= ST_LOOK;
        ST_LOOK: begin
          ov_r  <= 1'b1;
          st_r  <= ST_IDLE;
        end
        ST_HOLD: st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      sa_r   <= SA_W'(q_set);
      a_r    <= q_addr;
      lru_r  <= q_ctl.lru;
      ways_r <= q_ctl.ways;
    end
    if (st_r == ST_LOOK) begin
      oh_r  <= hit_c;
      orp_r <= rep_c;
    end
  end

endmodule

[test/set_assoc_cache_tag_store_tb.sv]
`timescale 1ns / 100ps

module set_assoc_cache_tag_store_tb;
  import sact_pkg::*;

  localparam int NSETS = DEF_MAX_SETS;
  localparam int NWAYS = DEF_MAX_WAYS;
  localparam int ABITS = DEF_ADDRESS_BITS;
  localparam int IDLE_LIMIT = 20000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [ABITS-1:0] in_block_address = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic             out_hit;
  logic             out_replaced;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  set_assoc_cache_tag_store DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_block_address(in_block_address),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_hit(out_hit), .out_replaced(out_replaced),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // shadow copy of the tag store
  logic [ABITS-1:0] shadow_tag [NSETS*NWAYS];
  logic             shadow_valid [NSETS*NWAYS];
  logic [2:0]       shadow_rank [NSETS*NWAYS];
  logic [3:0]       shadow_fill [NSETS];
  logic [3:0]       sh_index_bits;
  logic [3:0]       sh_ways;
  logic             sh_policy;

  typedef struct packed {
    logic hit;
    logic replaced;
  } lookup_t;

  lookup_t          expected_lookups[$];
  logic [ABITS-1:0] pending_addrs[$];
  logic [ABITS-1:0] used_addrs[$];

  int errors = 0;
  int n_hits = 0;
  int n_repl = 0;
  int n_results = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  bit feeding = 1'b0;

  // every valid line of the set younger than limit ages by one
  function automatic void age_lines(int base, int limit);
    for (int w = 0; w < NWAYS; w++)
      if (shadow_valid[base+w] && shadow_rank[base+w] < limit)
        shadow_rank[base+w]++;
  endfunction

  function automatic lookup_t predict_lookup(logic [ABITS-1:0] addr);
    lookup_t r;
    int bits, ways, set_no, base, pick, pick_rank, hr;
    r = '0;
    bits = (sh_index_bits > 8) ? 8 : sh_index_bits;
    ways = (sh_ways < 1) ? 1 : ((sh_ways > NWAYS) ? NWAYS : sh_ways);
    set_no = int'(addr & ((48'd1 << bits) - 1));
    base = set_no * NWAYS;
    for (int w = 0; w < NWAYS; w++) begin
      if (!r.hit && shadow_valid[base+w] && shadow_tag[base+w] == addr) begin
        r.hit = 1'b1;
        if (sh_policy == POLICY_LRU) begin
          hr = shadow_rank[base+w];
          age_lines(base, hr);
          shadow_rank[base+w] = '0;
        end
      end
    end
    if (!r.hit) begin
      if (shadow_fill[set_no] < ways) begin
        pick = 0;
        while (pick < NWAYS && shadow_valid[base+pick]) pick++;
        if (pick < NWAYS) begin
          age_lines(base, 255);
          shadow_valid[base+pick] = 1'b1;
          shadow_tag[base+pick] = addr;
          shadow_rank[base+pick] = '0;
          shadow_fill[set_no]++;
        end
      end else begin
        pick = NWAYS;
        pick_rank = 0;
        for (int w = 0; w < NWAYS; w++)
          if (shadow_valid[base+w] && (pick == NWAYS || shadow_rank[base+w] > pick_rank)) begin
            pick = w;
            pick_rank = shadow_rank[base+w];
          end
        if (pick < NWAYS) begin
          age_lines(base, pick_rank);
          shadow_tag[base+pick] = addr;
          shadow_rank[base+pick] = '0;
          r.replaced = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // driver: bursts of pushes separated by random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        expected_lookups.push_back(predict_lookup(in_block_address));
        void'(pending_addrs.pop_front());
      end
      if (!(in_push && in_full)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_push <= 1'b0;
        end else if (feeding && pending_addrs.size() > 0) begin
          in_push <= 1'b1;
          in_block_address <= pending_addrs[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // monitor: pop on a rotating stall pattern, check against oldest expectation
  always @(posedge clk) begin
    lookup_t exp_r;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        n_results++;
        if (expected_lookups.size() == 0) begin
          $display("%0t: unexpected result hit=%0b replaced=%0b", $time, out_hit,
                   out_replaced);
          errors++;
        end else begin
          exp_r = expected_lookups.pop_front();
          if (out_hit !== exp_r.hit) begin
            $display("%0t: hit mismatch expected %0b actual %0b", $time, exp_r.hit, out_hit);
            errors++;
          end
          if (out_replaced !== exp_r.replaced) begin
            $display("%0t: replaced mismatch expected %0b actual %0b", $time,
                     exp_r.replaced, out_replaced);
            errors++;
          end
          n_hits += exp_r.hit;
          n_repl += exp_r.replaced;
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      // stall windows in part of the pattern, free running elsewhere
      if (stall_phase < 40)
        out_pop <= 1'b1;
      else if (stall_phase < 70)
        out_pop <= ($urandom_range(0, 3) != 0);
      else
        out_pop <= ($urandom_range(0, 2) == 0);
      if ((in_push && !in_full) || (out_pop && !out_empty))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog timeout, %0d results outstanding", $time,
                 expected_lookups.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SET_INDEX_BITS: sh_index_bits = val;
      REG_WAYS_IN_USE:    sh_ways = val;
      default:            sh_policy = val[0];
    endcase
  endtask

  // let the queued lookups all complete, then settle the pipeline
  task automatic drain_lookups();
    feeding = 1'b1;
    while (pending_addrs.size() > 0 || in_push || expected_lookups.size() > 0)
      @(posedge clk);
    feeding = 1'b0;
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(logic [3:0] bits, logic [3:0] ways, logic pol);
    write_reg(REG_SET_INDEX_BITS, bits);
    write_reg(REG_WAYS_IN_USE, ways);
    write_reg(REG_REPLACE_POLICY, {3'b000, pol});
  endtask

  // mostly addresses that recur, others random within the span, a few fully random ones
  function automatic logic [ABITS-1:0] pick_address(int span);
    logic [ABITS-1:0] a;
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6 && used_addrs.size() > 0)
      a = used_addrs[$urandom_range(0, used_addrs.size() - 1)];
    else if (roll < 9)
      a = ABITS'({$urandom, $urandom}) & ((48'd1 << span) - 1);
    else
      a = ABITS'({$urandom, $urandom});
    if (used_addrs.size() < 64) used_addrs.push_back(a);
    else used_addrs[$urandom_range(0, 63)] = a;
    return a;
  endfunction

  initial begin
    int span;
    for (int s = 0; s < NSETS; s++) begin
      shadow_fill[s] = '0;
      for (int w = 0; w < NWAYS; w++) begin
        shadow_valid[s*NWAYS+w] = 1'b0;
        shadow_rank[s*NWAYS+w] = '0;
        shadow_tag[s*NWAYS+w] = '0;
      end
    end
    sh_index_bits = 4'd0;
    sh_ways = 4'd1;
    sh_policy = POLICY_LRU;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, then extremes of the address and of the ways
    pending_addrs.push_back('0);
    pending_addrs.push_back('0);
    pending_addrs.push_back({ABITS{1'b1}});
    pending_addrs.push_back('0);
    drain_lookups();
    // ways 0 acts as one, over-large index bits clamp, ways above max clamp
    apply_setting(4'd15, 4'd0, POLICY_FIFO);
    pending_addrs.push_back(48'h100);
    pending_addrs.push_back(48'h200);
    pending_addrs.push_back(48'h100);
    drain_lookups();
    apply_setting(4'd0, 4'd15, POLICY_LRU);
    for (int i = 0; i < 10; i++) pending_addrs.push_back(48'h5555_0000_0000 + i);
    pending_addrs.push_back(48'h5555_0000_0000);
    pending_addrs.push_back(48'hAAAA_AAAA_AAAA);
    drain_lookups();
    // lower the ways while the set is full: replacement keeps the fill
    write_reg(REG_WAYS_IN_USE, 4'd2);
    pending_addrs.push_back(48'h1234);
    pending_addrs.push_back(48'h5555_0000_0003);
    drain_lookups();
    // index bits changed with lines stored
    write_reg(REG_SET_INDEX_BITS, 4'd4);
    pending_addrs.push_back(48'h1234);
    pending_addrs.push_back(48'h5555_0000_0000);
    drain_lookups();

    // random phases over many settings
    for (int ph = 0; ph < 17; ph++) begin
      case (ph)
        0: apply_setting(4'd8, 4'd8, POLICY_LRU);
        1: apply_setting(4'd0, 4'd1, POLICY_FIFO);
        2: apply_setting(4'd0, 4'd8, POLICY_FIFO);
        default: apply_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                               1'($urandom_range(0, 1)));
      endcase
      span = sh_index_bits + $urandom_range(1, 5);
      for (int i = 0; i < 100; i++) pending_addrs.push_back(pick_address(span));
      drain_lookups();
    end

    $display("%0d lookups checked: %0d hits, %0d replacements", n_results, n_hits, n_repl);
    $display("directed corner settings plus 17 random setting phases under bursty traffic");
    if (errors == 0 && expected_lookups.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
